// ===== design/assert_macros.svh =====
// assertion helpers for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds at every clock edge outside reset
`define OLAD_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check of a sequence property (implication) outside reset
`define OLAD_ASSERT_SEQ(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== design/olad_pkg.sv =====
package olad_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_APPENDED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_ENTRY    = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_DELETE,
    CMD_ROTATE
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    cell_cmd_e               cmd;
    logic signed [DataW-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== design/olad_if.sv =====
interface olad_req_if;
  logic                             valid;
  logic                             ready;
  logic [olad_pkg::OpW-1:0]         opcode;
  logic signed [olad_pkg::DataW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface olad_res_if;
  logic                              valid;
  logic                              ready;
  logic [olad_pkg::StatusW-1:0]      status;
  logic signed [olad_pkg::DataW-1:0] value_res;
  logic                              last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

// ===== design/olad_cell.sv =====
module olad_cell #(
  parameter int unsigned Depth = olad_pkg::DepthDef,
  parameter int unsigned Index = 0,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                              clk_i,
  input  olad_pkg::cell_ctrl_t              ctrl_i,
  input  logic [CntW-1:0]                   count_i,
  input  logic signed [olad_pkg::DataW-1:0] next_i,
  input  logic signed [olad_pkg::DataW-1:0] head_i,
  input  logic                              found_i,
  output logic                              found_o,
  output logic signed [olad_pkg::DataW-1:0] entry_o
);
  import olad_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Index);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    valid, hit;

  assign valid   = MyIdx < count_i;
  assign hit     = valid && (entry_q == ctrl_i.key);
  assign found_o = found_i || hit;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_APPEND: begin
        if (MyIdx == count_i) entry_d = ctrl_i.key;
      end
      // close the gap: everything from the first match onward moves toward the head
      CMD_DELETE: begin
        if (found_i || hit) entry_d = next_i;
      end
      // tail slot takes the head so the list comes back after a full pass
      CMD_ROTATE: begin
        if (MyIdx == count_i - CntW'(1)) entry_d = head_i;
        else                             entry_d = next_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== design/ordered_list_append_delete.sv =====
// ordered list of up to Depth signed 32-bit values, head to tail, held in a
// row of cells. append (opcode 0) writes the value into the cell just past the
// tail; delete (opcode 1) compares every cell at once, the first match from the
// head and every cell behind it take their neighbor's value in the same cycle,
// so order is kept. both give one result, status plus the echoed value; a
// new request is taken every cycle while the result slot drains. dump (opcode
// 2) streams the list from the head, one entry per cycle while the result
// slot drains, by rotating the row one place toward the head for each entry,
// and no request is taken until the last entry has been loaded into the
// result slot. an empty dump gives a single empty result with value 0.
// opcode 3 is taken and dropped with no result. the list needs no clearing
// after reset; the fill count, dump state and result valid are reset.
`include "assert_macros.svh"

module ordered_list_append_delete #(
  parameter int unsigned Depth = olad_pkg::DepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olad_req_if.sink   req_i,
  olad_res_if.source res_o
);
  import olad_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  // control state
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;   // dump entries still to send

  // result slot
  logic                    res_valid_q, res_valid_d;
  status_e                 res_status_q, res_status_d;
  logic signed [DataW-1:0] res_value_q, res_value_d;
  logic                    res_last_q, res_last_d;

  // cell row
  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] entry [Depth];
  logic [Depth:0]          found;

  logic res_free, req_take;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] next_val;
    if (i == Depth - 1) begin : g_tail
      assign next_val = entry[i];
    end else begin : g_mid
      assign next_val = entry[i+1];
    end

    olad_cell #(
      .Depth (Depth),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .next_i  (next_val),
      .head_i  (entry[0]),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .entry_o (entry[i])
    );
  end

  // slot can take a new result when empty or being drained this cycle
  assign res_free    = !res_valid_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && res_free;
  assign req_take    = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_last_d   = res_last_q;
    ctrl.cmd     = CMD_NONE;
    ctrl.key     = req_i.value;

    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          case (req_i.opcode)
            OP_APPEND: begin
              res_valid_d = 1'b1;
              res_value_d = req_i.value;
              res_last_d  = 1'b1;
              if (count_q == FullCnt) begin
                res_status_d = STAT_FULL;
              end else begin
                res_status_d = STAT_APPENDED;
                ctrl.cmd     = CMD_APPEND;
                count_d      = count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              // cells only move when a match exists
              ctrl.cmd    = CMD_DELETE;
              res_valid_d = 1'b1;
              res_value_d = req_i.value;
              res_last_d  = 1'b1;
              if (found[Depth]) begin
                res_status_d = STAT_DELETED;
                count_d      = count_q - CntW'(1);
              end else begin
                res_status_d = STAT_NOTFOUND;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_EMPTY;
                res_value_d  = '0;
                res_last_d   = 1'b1;
              end else begin
                state_d  = ST_DUMP;
                remain_d = count_q;
              end
            end
            default: ;  // unused opcode, dropped
          endcase
        end
      end
      ST_DUMP: begin
        // head goes out, row rotates so the next entry sits at the head
        if (res_free) begin
          ctrl.cmd     = CMD_ROTATE;
          res_valid_d  = 1'b1;
          res_status_d = STAT_ENTRY;
          res_value_d  = entry[0];
          res_last_d   = (remain_q == CntW'(1));
          remain_d     = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_last_q   <= res_last_d;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.status    = res_status_q;
  assign res_o.value_res = res_value_q;
  assign res_o.last      = res_last_q;

  // fill count never passes the row length
  `OLAD_ASSERT(a_count_range, count_q <= FullCnt, "list count beyond depth")
  // list size is frozen while a dump streams out
  `OLAD_ASSERT_SEQ(a_dump_count_stable, (state_q == ST_DUMP |=> $stable(count_q)), "count changed during dump")
  // a dump always covers at least one entry still to send
  `OLAD_ASSERT(a_dump_remain, state_q != ST_DUMP || (remain_q != '0 && remain_q <= count_q), "dump counter out of range")
  // leaving the dump state must coincide with loading the final entry
  `OLAD_ASSERT_SEQ(a_dump_end_last, (state_q == ST_DUMP ##1 state_q == ST_IDLE |-> res_valid_q && res_last_q && res_status_q == STAT_ENTRY), "dump ended without final entry")

endmodule
